>>> design/cpec_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and arithmetic helpers of the circle pair collision unit.
// No dependencies; imported by every module of the block.
package cpec_pkg;

    localparam int unsigned IN_W       = 224;
    localparam int unsigned OUT_W      = 200;
    localparam int unsigned NORM_SHIFT = 30;
    localparam int unsigned MASS_SHIFT = 28;
    localparam int unsigned D2_W       = 50;   // dx^2 + dy^2
    localparam int unsigned ROOT_W     = D2_W / 2;
    localparam int unsigned Q_W        = 31;   // quotient bits, normal and mass
    localparam int unsigned NDEN_W     = ROOT_W;
    localparam int unsigned NNUM_W     = ROOT_W + NORM_SHIFT;
    localparam int unsigned MDEN_W     = 33;
    localparam int unsigned MNUM_W     = 62;

    typedef struct packed {
        logic signed [23:0] vy;
        logic signed [23:0] vx;
        logic signed [23:0] py;
        logic signed [23:0] px;
    } t_circ;

    typedef struct packed {
        logic [15:0] radius_b;
        t_circ       b;
        logic [15:0] radius_a;
        t_circ       a;
    } t_in;

    typedef struct packed {
        logic [6:0]         pad;
        logic signed [23:0] new_vel_b_y;
        logic signed [23:0] new_vel_b_x;
        logic signed [23:0] new_pos_b_y;
        logic signed [23:0] new_pos_b_x;
        logic signed [23:0] new_vel_a_y;
        logic signed [23:0] new_vel_a_x;
        logic signed [23:0] new_pos_a_y;
        logic signed [23:0] new_pos_a_x;
        logic               collided;
    } t_out;

    // arithmetic shift right, rounded to nearest, ties away from zero
    function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                                input int unsigned s);
        logic signed [63:0] bias;
        bias = (64'sd1 <<< (s - 1)) - ((v < 0) ? 64'sd1 : 64'sd0);
        return (v + bias) >>> s;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        logic signed [23:0] r;
        if (v > 64'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -64'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

>>> design/cpec_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, floor(sqrt(x)), one result bit per stage.
// Uses cpec_pkg for the default width.
module cpec_sqrt import cpec_pkg::*; #(
    parameter int unsigned IN_W_P = D2_W
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [IN_W_P-1:0]     i_x,
    output logic [IN_W_P/2-1:0]   o_root
);
    localparam int unsigned RW    = IN_W_P / 2;
    localparam int unsigned REM_W = RW + 2;

    logic [IN_W_P-1:0] r_x    [RW];
    logic [RW-1:0]     r_root [RW];
    logic [REM_W-1:0]  r_rem  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [IN_W_P-1:0] x_in;
        logic [RW-1:0]     root_in;
        logic [REM_W-1:0]  rem_in;
        logic [REM_W+1:0]  rem_t;
        logic [REM_W+1:0]  trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign x_in    = i_x;
            assign root_in = '0;
            assign rem_in  = '0;
        end else begin : g_next
            assign x_in    = r_x[k-1];
            assign root_in = r_root[k-1];
            assign rem_in  = r_rem[k-1];
        end

        assign rem_t = {rem_in, x_in[IN_W_P-1 -: 2]};
        assign trial = (REM_W + 2)'({root_in, 2'b01});
        assign ge    = (rem_t >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= x_in << 2;
                r_root[k] <= {root_in[RW-2:0], ge};
                r_rem[k]  <= ge ? REM_W'(rem_t - trial) : REM_W'(rem_t);
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

>>> design/cpec_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage (truncating).
// The upper numerator bits above the quotient must be below the divisor.
module cpec_div import cpec_pkg::*; #(
    parameter int unsigned NUM_W_P = NNUM_W,
    parameter int unsigned DEN_W_P = NDEN_W,
    parameter int unsigned Q_W_P   = Q_W
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [NUM_W_P-1:0] i_num,
    input  logic [DEN_W_P-1:0] i_den,
    output logic [Q_W_P-1:0]   o_q
);
    logic [DEN_W_P-1:0] r_rem [Q_W_P];
    logic [DEN_W_P-1:0] r_den [Q_W_P];
    logic [Q_W_P-1:0]   r_lo  [Q_W_P];
    logic [Q_W_P-1:0]   r_q   [Q_W_P];

    for (genvar k = 0; k < Q_W_P; k++) begin : g_stage
        logic [DEN_W_P-1:0] rem_in;
        logic [DEN_W_P-1:0] den_in;
        logic [Q_W_P-1:0]   lo_in;
        logic [Q_W_P-1:0]   q_in;
        logic [DEN_W_P:0]   rem_t;
        logic               ge;

        if (k == 0) begin : g_first
            assign rem_in = DEN_W_P'(i_num[NUM_W_P-1:Q_W_P]);
            assign den_in = i_den;
            assign lo_in  = i_num[Q_W_P-1:0];
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign lo_in  = r_lo[k-1];
            assign q_in   = r_q[k-1];
        end

        assign rem_t = {rem_in, lo_in[Q_W_P-1]};
        assign ge    = (rem_t >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? DEN_W_P'(rem_t - {1'b0, den_in}) : DEN_W_P'(rem_t);
                r_den[k] <= den_in;
                r_lo[k]  <= lo_in << 1;
                r_q[k]   <= {q_in[Q_W_P-2:0], ge};
            end
        end
    end

    assign o_q = r_q[Q_W_P-1];

endmodule

>>> design/circle_pair_elastic_collision_unit.sv
`timescale 1ns / 1ps
// Two-circle elastic collision resolver: overlap test, push-apart, normal exchange.
// One circle pair per cycle while o_s_tready is high; the whole pipeline stalls while the skid register is full.
// Depth: 3 front stages, 25-stage square root, 31-stage dividers, 10 back stages.
// Output skid register: input ready drops only while it holds a result.
// Reset (i_rst_n low, synchronous) empties the pipeline and the skid register.
// Depends on cpec_pkg, cpec_sqrt and cpec_div.
module circle_pair_elastic_collision_unit import cpec_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // pos_a_x, pos_a_y, vel_a_x, vel_a_y, radius_a, pos_b_x, pos_b_y, vel_b_x,
    // vel_b_y, radius_b (lowest bit first)
    input  logic [IN_W-1:0]  i_s_tdata,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // collided, new_pos_a_x, new_pos_a_y, new_vel_a_x, new_vel_a_y, new_pos_b_x,
    // new_pos_b_y, new_vel_b_x, new_vel_b_y, 7 zero bits (lowest bit first)
    output logic [OUT_W-1:0] o_m_tdata
);
    // stage count: front, root, divide, back
    localparam int unsigned E1_IDX = 3 + ROOT_W + Q_W;
    localparam int unsigned LAT    = E1_IDX + 10;

    typedef struct packed {
        t_circ              a;
        t_circ              b;
        logic [15:0]        ra;
        logic [15:0]        rb;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
    } t_p1;

    typedef struct packed {
        t_circ              a;
        t_circ              b;
        logic [16:0]        rsum;
        logic [31:0]        ma;
        logic [31:0]        mb;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic [48:0]        dx2;
        logic [48:0]        dy2;
        logic [33:0]        rs2;
    } t_p2;

    // travels beside the square root
    typedef struct packed {
        t_circ              a;
        t_circ              b;
        logic               hit;
        logic               zero;
        logic [16:0]        rsum;
        logic [31:0]        ma;
        logic [31:0]        mb;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
    } t_sq;

    // travels beside the dividers
    typedef struct packed {
        t_circ              a;
        t_circ              b;
        logic               hit;
        logic               zero;
        logic signed [17:0] ov;
        logic               sx;
        logic               sy;
    } t_dv;

    // back end, filled in stage by stage
    typedef struct packed {
        t_circ              a;
        t_circ              b;
        logic               hit;
        logic               zero;
        logic signed [17:0] ov;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] ka;
        logic signed [31:0] kb;
        logic signed [49:0] m_cx;
        logic signed [49:0] m_cy;
        logic signed [55:0] m_ax;
        logic signed [55:0] m_ay;
        logic signed [55:0] m_bx;
        logic signed [55:0] m_by;
        logic signed [24:0] cx;
        logic signed [24:0] cy;
        logic signed [56:0] sa;
        logic signed [56:0] sb;
        logic signed [26:0] vna;
        logic signed [26:0] vnb;
        logic signed [23:0] np_ax;
        logic signed [23:0] np_ay;
        logic signed [23:0] np_bx;
        logic signed [23:0] np_by;
        logic signed [27:0] dvn;
        logic signed [59:0] m_ia;
        logic signed [59:0] m_ib;
        logic signed [31:0] ia;
        logic signed [31:0] ib;
        logic signed [63:0] m_iax;
        logic signed [63:0] m_iay;
        logic signed [63:0] m_ibx;
        logic signed [63:0] m_iby;
        logic signed [33:0] rax;
        logic signed [33:0] ray;
        logic signed [33:0] rbx;
        logic signed [33:0] rby;
    } t_post;

    t_in  s_in;
    logic en;

    logic [LAT-1:0] r_v;
    t_p1             r_p1, n_p1;
    t_p2             r_p2, n_p2;
    t_sq             r_p3, n_p3;
    logic [D2_W-1:0] r_d2, n_d2;
    t_sq             r_sq [ROOT_W];
    t_dv             r_dv [Q_W];
    t_post           r_e  [1:9];
    t_post           n_e  [1:9];
    t_out            r_out, n_out;
    t_out            r_skid;
    logic            r_skid_v;

    // divider inputs / outputs
    logic [ROOT_W-1:0] root_d;
    logic [24:0]       mag_x, mag_y;
    logic [NNUM_W-1:0] num_x, num_y;
    logic [MDEN_W-1:0] msum;
    logic [MNUM_W-1:0] num_ka, num_kb;
    logic [Q_W-1:0]    q_x, q_y, q_ka, q_kb;
    t_dv               n_dv0;

    assign s_in       = t_in'(i_s_tdata);
    assign en         = ~r_skid_v;
    assign o_s_tready = en;
    assign o_m_tvalid = r_skid_v | r_v[LAT-1];
    assign o_m_tdata  = r_skid_v ? OUT_W'(r_skid) : OUT_W'(r_out);

    // valid line and skid register: the only reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            r_skid_v <= 1'b0;
        end else begin
            if (en) begin
                r_v <= {r_v[LAT-2:0], i_s_tvalid};
            end
            if (r_skid_v) begin
                if (i_m_tready) begin
                    r_skid_v <= 1'b0;
                end
            end else if (r_v[LAT-1] && !i_m_tready) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v && r_v[LAT-1] && !i_m_tready) begin
            r_skid <= r_out;
        end
    end

    // front end: differences, squares, overlap test
    always_comb begin
        logic signed [49:0] sq_x;
        logic signed [49:0] sq_y;
        n_p1.a  = s_in.a;
        n_p1.b  = s_in.b;
        n_p1.ra = s_in.radius_a;
        n_p1.rb = s_in.radius_b;
        n_p1.dx = 25'(s_in.b.px) - 25'(s_in.a.px);
        n_p1.dy = 25'(s_in.b.py) - 25'(s_in.a.py);

        sq_x      = 50'(r_p1.dx) * 50'(r_p1.dx);
        sq_y      = 50'(r_p1.dy) * 50'(r_p1.dy);
        n_p2.a    = r_p1.a;
        n_p2.b    = r_p1.b;
        n_p2.rsum = 17'(r_p1.ra) + 17'(r_p1.rb);
        n_p2.ma   = 32'(r_p1.ra) * 32'(r_p1.ra);
        n_p2.mb   = 32'(r_p1.rb) * 32'(r_p1.rb);
        n_p2.dx   = r_p1.dx;
        n_p2.dy   = r_p1.dy;
        n_p2.dx2  = sq_x[48:0];
        n_p2.dy2  = sq_y[48:0];
        n_p2.rs2  = 34'(n_p2.rsum) * 34'(n_p2.rsum);

        n_d2      = D2_W'(r_p2.dx2) + D2_W'(r_p2.dy2);
        n_p3.a    = r_p2.a;
        n_p3.b    = r_p2.b;
        n_p3.hit  = (n_d2 < D2_W'(r_p2.rs2));
        n_p3.zero = (n_d2 == '0);
        n_p3.rsum = r_p2.rsum;
        n_p3.ma   = r_p2.ma;
        n_p3.mb   = r_p2.mb;
        n_p3.dx   = r_p2.dx;
        n_p3.dy   = r_p2.dy;
    end

    // rsum is needed at stage 2 for the radius-sum square; recomputed there
    // from stage 1 radii, so the stage 2 value is what travels on

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            r_p3 <= n_p3;
            r_d2 <= n_d2;
        end
    end

    cpec_sqrt #(
        .IN_W_P (D2_W)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (r_d2),
        .o_root (root_d)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq[0] <= r_p3;
            for (int k = 1; k < ROOT_W; k++) begin
                r_sq[k] <= r_sq[k-1];
            end
        end
    end

    // divider set-up: rounding by adding half the divisor to the numerator
    always_comb begin
        t_sq s;
        s      = r_sq[ROOT_W-1];
        mag_x  = s.dx[24] ? 25'(-s.dx) : 25'(s.dx);
        mag_y  = s.dy[24] ? 25'(-s.dy) : 25'(s.dy);
        num_x  = NNUM_W'({mag_x, {NORM_SHIFT{1'b0}}}) + NNUM_W'(root_d >> 1);
        num_y  = NNUM_W'({mag_y, {NORM_SHIFT{1'b0}}}) + NNUM_W'(root_d >> 1);
        msum   = MDEN_W'(s.ma) + MDEN_W'(s.mb);
        num_ka = MNUM_W'({s.ma, 1'b0, {MASS_SHIFT{1'b0}}}) + MNUM_W'(msum >> 1);
        num_kb = MNUM_W'({s.mb, 1'b0, {MASS_SHIFT{1'b0}}}) + MNUM_W'(msum >> 1);

        n_dv0.a    = s.a;
        n_dv0.b    = s.b;
        n_dv0.hit  = s.hit;
        n_dv0.zero = s.zero;
        n_dv0.ov   = 18'(s.rsum) - 18'(root_d);
        n_dv0.sx   = s.dx[24];
        n_dv0.sy   = s.dy[24];
    end

    cpec_div #(.NUM_W_P(NNUM_W), .DEN_W_P(NDEN_W), .Q_W_P(Q_W)) u_div_nx (
        .i_clk (i_clk), .i_en (en), .i_num (num_x), .i_den (root_d), .o_q (q_x)
    );

    cpec_div #(.NUM_W_P(NNUM_W), .DEN_W_P(NDEN_W), .Q_W_P(Q_W)) u_div_ny (
        .i_clk (i_clk), .i_en (en), .i_num (num_y), .i_den (root_d), .o_q (q_y)
    );

    cpec_div #(.NUM_W_P(MNUM_W), .DEN_W_P(MDEN_W), .Q_W_P(Q_W)) u_div_ka (
        .i_clk (i_clk), .i_en (en), .i_num (num_ka), .i_den (msum), .o_q (q_ka)
    );

    cpec_div #(.NUM_W_P(MNUM_W), .DEN_W_P(MDEN_W), .Q_W_P(Q_W)) u_div_kb (
        .i_clk (i_clk), .i_en (en), .i_num (num_kb), .i_den (msum), .o_q (q_kb)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0] <= n_dv0;
            for (int k = 1; k < Q_W; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    // back end: one multiply or one add/round per stage
    always_comb begin
        t_dv                d;
        logic signed [63:0] t0, t1, t2, t3;
        d = r_dv[Q_W-1];

        // E1: signed normal and mass factors
        n_e[1]      = '0;
        n_e[1].a    = d.a;
        n_e[1].b    = d.b;
        n_e[1].hit  = d.hit;
        n_e[1].zero = d.zero;
        n_e[1].ov   = d.ov;
        n_e[1].nx   = d.sx ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
        n_e[1].ny   = d.sy ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
        n_e[1].ka   = $signed({1'b0, q_ka});
        n_e[1].kb   = $signed({1'b0, q_kb});

        // E2: push and normal-speed products
        n_e[2]      = r_e[1];
        n_e[2].m_cx = 50'(r_e[1].ov) * 50'(r_e[1].nx);
        n_e[2].m_cy = 50'(r_e[1].ov) * 50'(r_e[1].ny);
        n_e[2].m_ax = 56'(r_e[1].a.vx) * 56'(r_e[1].nx);
        n_e[2].m_ay = 56'(r_e[1].a.vy) * 56'(r_e[1].ny);
        n_e[2].m_bx = 56'(r_e[1].b.vx) * 56'(r_e[1].nx);
        n_e[2].m_by = 56'(r_e[1].b.vy) * 56'(r_e[1].ny);

        // E3: half-overlap push, dot-product sums
        n_e[3]    = r_e[2];
        t0        = rshr(64'(r_e[2].m_cx), NORM_SHIFT + 1);
        t1        = rshr(64'(r_e[2].m_cy), NORM_SHIFT + 1);
        n_e[3].cx = t0[24:0];
        n_e[3].cy = t1[24:0];
        n_e[3].sa = 57'(r_e[2].m_ax) + 57'(r_e[2].m_ay);
        n_e[3].sb = 57'(r_e[2].m_bx) + 57'(r_e[2].m_by);

        // E4: normal speeds, pushed positions
        n_e[4]       = r_e[3];
        t2           = rshr(64'(r_e[3].sa), NORM_SHIFT);
        t3           = rshr(64'(r_e[3].sb), NORM_SHIFT);
        n_e[4].vna   = t2[26:0];
        n_e[4].vnb   = t3[26:0];
        n_e[4].np_ax = sat24(64'(r_e[3].a.px) - 64'(r_e[3].cx));
        n_e[4].np_ay = sat24(64'(r_e[3].a.py) - 64'(r_e[3].cy));
        n_e[4].np_bx = sat24(64'(r_e[3].b.px) + 64'(r_e[3].cx));
        n_e[4].np_by = sat24(64'(r_e[3].b.py) + 64'(r_e[3].cy));

        // E5: relative normal speed
        n_e[5]     = r_e[4];
        n_e[5].dvn = 28'(r_e[4].vnb) - 28'(r_e[4].vna);

        // E6: impulse products
        n_e[6]      = r_e[5];
        n_e[6].m_ia = 60'(r_e[5].dvn) * 60'(r_e[5].kb);
        n_e[6].m_ib = 60'(r_e[5].dvn) * 60'(r_e[5].ka);

        // E7: impulses
        n_e[7]    = r_e[6];
        t0        = rshr(64'(r_e[6].m_ia), MASS_SHIFT);
        t1        = rshr(64'(r_e[6].m_ib), MASS_SHIFT);
        n_e[7].ia = t0[31:0];
        n_e[7].ib = t1[31:0];

        // E8: impulse along the normal
        n_e[8]       = r_e[7];
        n_e[8].m_iax = 64'(r_e[7].ia) * 64'(r_e[7].nx);
        n_e[8].m_iay = 64'(r_e[7].ia) * 64'(r_e[7].ny);
        n_e[8].m_ibx = 64'(r_e[7].ib) * 64'(r_e[7].nx);
        n_e[8].m_iby = 64'(r_e[7].ib) * 64'(r_e[7].ny);

        // E9: velocity changes
        n_e[9]     = r_e[8];
        t0         = rshr(r_e[8].m_iax, NORM_SHIFT);
        t1         = rshr(r_e[8].m_iay, NORM_SHIFT);
        t2         = rshr(r_e[8].m_ibx, NORM_SHIFT);
        t3         = rshr(r_e[8].m_iby, NORM_SHIFT);
        n_e[9].rax = t0[33:0];
        n_e[9].ray = t1[33:0];
        n_e[9].rbx = t2[33:0];
        n_e[9].rby = t3[33:0];

        // E10: result selection; misses pass through, coincident centres stop
        n_out          = '0;
        n_out.collided = r_e[9].hit;
        priority if (!r_e[9].hit) begin
            n_out.new_pos_a_x = r_e[9].a.px;
            n_out.new_pos_a_y = r_e[9].a.py;
            n_out.new_vel_a_x = r_e[9].a.vx;
            n_out.new_vel_a_y = r_e[9].a.vy;
            n_out.new_pos_b_x = r_e[9].b.px;
            n_out.new_pos_b_y = r_e[9].b.py;
            n_out.new_vel_b_x = r_e[9].b.vx;
            n_out.new_vel_b_y = r_e[9].b.vy;
        end else if (r_e[9].zero) begin
            n_out.new_pos_a_x = r_e[9].a.px;
            n_out.new_pos_a_y = r_e[9].a.py;
            n_out.new_pos_b_x = r_e[9].b.px;
            n_out.new_pos_b_y = r_e[9].b.py;
        end else begin
            n_out.new_pos_a_x = r_e[9].np_ax;
            n_out.new_pos_a_y = r_e[9].np_ay;
            n_out.new_pos_b_x = r_e[9].np_bx;
            n_out.new_pos_b_y = r_e[9].np_by;
            n_out.new_vel_a_x = sat24(64'(r_e[9].a.vx) + 64'(r_e[9].rax));
            n_out.new_vel_a_y = sat24(64'(r_e[9].a.vy) + 64'(r_e[9].ray));
            n_out.new_vel_b_x = sat24(64'(r_e[9].b.vx) - 64'(r_e[9].rbx));
            n_out.new_vel_b_y = sat24(64'(r_e[9].b.vy) - 64'(r_e[9].rby));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 1; k <= 9; k++) begin
                r_e[k] <= n_e[k];
            end
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    // a held result in the skid register is neither lost nor altered
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && !i_m_tready |=> r_skid_v && $stable(r_skid))
        else $error("skid register changed while stalled");

    // the skid register only fills from a result that was refused
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_v[LAT-1] && !i_m_tready))
        else $error("skid register filled without a refused result");

    // unit normal from the dividers never exceeds one in magnitude
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[E1_IDX] && r_e[1].hit && !r_e[1].zero |->
            (r_e[1].nx <= 32'sd1073741824) && (r_e[1].nx >= -32'sd1073741824) &&
            (r_e[1].ny <= 32'sd1073741824) && (r_e[1].ny >= -32'sd1073741824))
        else $error("normal component out of range");
`endif

endmodule
